@@ rtl/brb_pkg.sv @@
package brb_pkg;

  localparam int DEPTH     = 1024;
  localparam int MAX_BURST = 64;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int SIZE_W    = ADDR_W + 1;
  localparam int SIZE_RST  = (DEPTH < 1024) ? DEPTH : 1024;

  localparam int OP_W      = 3;
  localparam int DATA_W    = 8;
  localparam int REQ_W     = 7;
  localparam int OFFS_W    = 10;
  localparam int BUFSIZE_W = 11;
  localparam int COUNT_W   = 10;
  localparam int FREE_W    = 11;

  typedef enum logic [OP_W-1:0] {
    OpPush      = 3'd0,
    OpPop       = 3'd1,
    OpFlush     = 3'd2,
    OpCurFirst  = 3'd3,
    OpCurNext   = 3'd4,
    OpCurPeek   = 3'd5,
    OpPopCursor = 3'd6
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data_in;
    logic [REQ_W-1:0]  req_count;
    logic [OFFS_W-1:0] cursor_offset;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  data_out;
    logic               data_valid;
    logic               last;
    logic [COUNT_W-1:0] done_count;
    logic [COUNT_W-1:0] fill_count;
    logic [FREE_W-1:0]  free_count;
  } res_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] done_count;
    logic [COUNT_W-1:0] fill_count;
    logic [FREE_W-1:0]  free_count;
  } meta_t;

  typedef struct packed {
    logic              go;
    logic              single;
    logic [ADDR_W-1:0] src;
    logic [REQ_W-1:0]  count;
    logic [SIZE_W-1:0] size;
    meta_t             meta;
  } cmd_t;

  // Position plus step, wrapped at the size; the sum stays below twice the size.
  function automatic logic [ADDR_W-1:0] adv(input logic [ADDR_W-1:0] pos,
                                            input logic [SIZE_W-1:0] n,
                                            input logic [SIZE_W-1:0] size);
    logic [SIZE_W:0] s;
    s = (SIZE_W+1)'(pos) + (SIZE_W+1)'(n);
    if (s >= (SIZE_W+1)'(size)) begin
      s = s - (SIZE_W+1)'(size);
    end
    return ADDR_W'(s);
  endfunction

  // Distance from one position forward to another, wrapped at the size.
  function automatic logic [ADDR_W-1:0] ring_dist(input logic [ADDR_W-1:0] to,
                                                  input logic [ADDR_W-1:0] from,
                                                  input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] s;
    if (to >= from) begin
      s = SIZE_W'(to) - SIZE_W'(from);
    end else begin
      s = size - SIZE_W'(from) + SIZE_W'(to);
    end
    return ADDR_W'(s);
  endfunction

endpackage

@@ rtl/byte_ring_buffer_with_cursor_unit.sv @@
// Byte ring buffer with a scan cursor, held in one synchronous byte memory with a
// single read port. Push, flush, cursor first, cursor next and pop to cursor, and any pop
// or peek that returns no bytes, finish in the cycle they are accepted and give one result.
// Pop and cursor peek read one byte per cycle from the memory while the output register is
// free; a request that returns n bytes gives n results, each read from the memory and then
// registered, and the next request is taken once its last result sits in the output
// register and that register is free. Writing the size register zeroes both pointers and
// the cursor; the user must write it only while the unit is idle; the unit does not enforce it.
module byte_ring_buffer_with_cursor_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [brb_pkg::BUFSIZE_W-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  brb_pkg::req_t                     in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output brb_pkg::res_t                     out_res_o
);

  logic [brb_pkg::ADDR_W-1:0] rd_q, rd_d, wr_q, wr_d, cur_q, cur_d;
  logic [brb_pkg::SIZE_W-1:0] size_q, size_cfg;
  logic [brb_pkg::ADDR_W-1:0] fill, fill_after, span, done, src;
  logic [brb_pkg::REQ_W-1:0]  req_cap, nb;
  logic [brb_pkg::SIZE_W:0]   np;
  logic [brb_pkg::SIZE_W-1:0] free;
  logic                       ok, accept, idle, mem_we, rd_en;
  logic [brb_pkg::ADDR_W-1:0] rd_addr;
  logic [brb_pkg::DATA_W-1:0] rd_data;
  brb_pkg::cmd_t              cmd;

  assign accept     = in_valid_i && idle;
  assign in_ready_o = idle;

  assign size_cfg = (cfg_data_i == '0) ? brb_pkg::SIZE_W'(1) :
                    (int'(cfg_data_i) > brb_pkg::DEPTH) ? brb_pkg::SIZE_W'(brb_pkg::DEPTH) :
                    brb_pkg::SIZE_W'(cfg_data_i);

  always_comb begin
    rd_d    = rd_q;
    wr_d    = wr_q;
    cur_d   = cur_q;
    ok      = 1'b0;
    done    = '0;
    nb      = '0;
    src     = '0;
    span    = '0;
    np      = '0;
    mem_we  = 1'b0;
    fill    = brb_pkg::ring_dist(wr_q, rd_q, size_q);
    req_cap = (int'(in_req_i.req_count) > brb_pkg::MAX_BURST) ?
              brb_pkg::REQ_W'(brb_pkg::MAX_BURST) : in_req_i.req_count;

    unique case (brb_pkg::op_e'(in_req_i.op))
      brb_pkg::OpPush: begin
        mem_we = accept;
        wr_d   = brb_pkg::adv(wr_q, brb_pkg::SIZE_W'(1), size_q);
        ok     = 1'b1;
        done   = brb_pkg::ADDR_W'(1);
      end
      brb_pkg::OpPop: begin
        ok   = (fill != '0);
        nb   = (fill < brb_pkg::ADDR_W'(req_cap)) ? brb_pkg::REQ_W'(fill) : req_cap;
        src  = rd_q;
        rd_d = brb_pkg::adv(rd_q, brb_pkg::SIZE_W'(nb), size_q);
        done = brb_pkg::ADDR_W'(nb);
      end
      brb_pkg::OpFlush: begin
        rd_d = '0;
        wr_d = '0;
        ok   = 1'b1;
      end
      brb_pkg::OpCurFirst: begin
        if (fill != '0) begin
          cur_d = rd_q;
          ok    = 1'b1;
        end
      end
      brb_pkg::OpCurNext: begin
        np = (brb_pkg::SIZE_W+1)'(cur_q) + (brb_pkg::SIZE_W+1)'(in_req_i.cursor_offset);
        if (fill != '0) begin
          ok = 1'b1;
          if (rd_q < wr_q) begin
            if (np >= (brb_pkg::SIZE_W+1)'(wr_q) || np < (brb_pkg::SIZE_W+1)'(rd_q)) begin
              ok = 1'b0;
            end
          end else if (cur_q >= rd_q && brb_pkg::SIZE_W'(cur_q) < size_q) begin
            if (np >= (brb_pkg::SIZE_W+1)'(size_q)) begin
              np = np - (brb_pkg::SIZE_W+1)'(size_q);
              if (np >= (brb_pkg::SIZE_W+1)'(wr_q)) begin
                ok = 1'b0;
              end
            end
          end else if (np >= (brb_pkg::SIZE_W+1)'(wr_q)) begin
            ok = 1'b0;
          end
          if (ok) begin
            cur_d = brb_pkg::ADDR_W'(np);
          end
        end
      end
      brb_pkg::OpCurPeek: begin
        if (req_cap == brb_pkg::REQ_W'(1)) begin
          nb = brb_pkg::REQ_W'(1);
          ok = 1'b1;
        end else begin
          span = brb_pkg::ring_dist(wr_q, cur_q, size_q);
          nb   = (span < brb_pkg::ADDR_W'(req_cap)) ? brb_pkg::REQ_W'(span) : req_cap;
          ok   = (nb != '0);
        end
        src  = cur_q;
        done = brb_pkg::ADDR_W'(nb);
      end
      brb_pkg::OpPopCursor: begin
        span = brb_pkg::ring_dist(cur_q, rd_q, size_q);
        ok   = (fill != '0);
        if (fill != '0) begin
          done = (fill < span) ? fill : span;
          rd_d = brb_pkg::adv(rd_q, brb_pkg::SIZE_W'(done), size_q);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    fill_after = brb_pkg::ring_dist(wr_d, rd_d, size_q);
    free       = size_q - brb_pkg::SIZE_W'(fill_after);
  end

  always_comb begin
    cmd.go              = accept;
    cmd.single          = (nb == '0);
    cmd.src             = src;
    cmd.count           = nb;
    cmd.size            = size_q;
    cmd.meta.ok         = ok;
    cmd.meta.done_count = brb_pkg::COUNT_W'(done);
    cmd.meta.fill_count = brb_pkg::COUNT_W'(fill_after);
    cmd.meta.free_count = brb_pkg::FREE_W'(free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      wr_q   <= '0;
      cur_q  <= '0;
      size_q <= brb_pkg::SIZE_W'(brb_pkg::SIZE_RST);
    end else if (cfg_we_i) begin
      rd_q   <= '0;
      wr_q   <= '0;
      cur_q  <= '0;
      size_q <= size_cfg;
    end else if (accept) begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cur_q <= cur_d;
    end
  end

  brb_ram #(
    .WIDTH(brb_pkg::DATA_W),
    .DEPTH(brb_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(wr_q),
    .wdata_i(in_req_i.data_in),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  brb_stream u_stream (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .idle_o     (idle),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

endmodule

@@ rtl/brb_ram.sv @@
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/brb_stream.sv @@
module brb_stream (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  brb_pkg::cmd_t                        cmd_i,
  output logic                                 idle_o,
  output logic                                 rd_en_o,
  output logic [brb_pkg::ADDR_W-1:0]           rd_addr_o,
  input  logic [brb_pkg::DATA_W-1:0]           rd_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output brb_pkg::res_t                        out_res_o
);

  logic [brb_pkg::REQ_W-1:0]  rem_q, rem_d;
  logic [brb_pkg::ADDR_W-1:0] addr_q, addr_d;
  brb_pkg::meta_t             meta_q, meta_d;
  logic                       pend_q, pend_d;
  logic                       pend_last_q, pend_last_d;
  logic                       out_valid_q, out_valid_d;
  brb_pkg::res_t              out_res_q, out_res_d;
  logic                       out_free, load, issue;

  assign out_free  = !out_valid_q || out_ready_i;
  assign load      = pend_q && out_free;
  assign issue     = (rem_q != '0) && (!pend_q || load);
  assign idle_o    = (rem_q == '0) && !pend_q && out_free;
  assign rd_en_o   = issue;
  assign rd_addr_o = addr_q;

  always_comb begin
    rem_d       = rem_q;
    addr_d      = addr_q;
    meta_d      = meta_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;

    if (issue) begin
      rem_d       = rem_q - brb_pkg::REQ_W'(1);
      addr_d      = (brb_pkg::SIZE_W'(addr_q) == cmd_i.size - brb_pkg::SIZE_W'(1)) ?
                    '0 : addr_q + brb_pkg::ADDR_W'(1);
      pend_d      = 1'b1;
      pend_last_d = (rem_q == brb_pkg::REQ_W'(1));
    end else if (load) begin
      pend_d = 1'b0;
    end

    if (cmd_i.go) begin
      meta_d = cmd_i.meta;
      if (!cmd_i.single) begin
        rem_d  = cmd_i.count;
        addr_d = cmd_i.src;
      end
    end

    if (cmd_i.go && cmd_i.single) begin
      out_valid_d          = 1'b1;
      out_res_d.ok         = cmd_i.meta.ok;
      out_res_d.data_out   = '0;
      out_res_d.data_valid = 1'b0;
      out_res_d.last       = 1'b1;
      out_res_d.done_count = cmd_i.meta.done_count;
      out_res_d.fill_count = cmd_i.meta.fill_count;
      out_res_d.free_count = cmd_i.meta.free_count;
    end else if (load) begin
      out_valid_d          = 1'b1;
      out_res_d.ok         = meta_q.ok;
      out_res_d.data_out   = rd_data_i;
      out_res_d.data_valid = 1'b1;
      out_res_d.last       = pend_last_q;
      out_res_d.done_count = meta_q.done_count;
      out_res_d.fill_count = meta_q.fill_count;
      out_res_d.free_count = meta_q.free_count;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    meta_q      <= meta_d;
    pend_last_q <= pend_last_d;
    out_res_q   <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule
